// ===== rtl/plv_pkg.sv =====
// Shared types, register indexes and small arithmetic helpers for the
// point light vertex shading block. No dependencies.
package plv_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned AddrWidth  = 5;

    typedef logic signed [31:0] q16_t;

    typedef enum logic [2:0] {
        REG_LIGHT_X     = 3'd0,
        REG_LIGHT_Y     = 3'd1,
        REG_LIGHT_Z     = 3'd2,
        REG_LIGHT_R     = 3'd3,
        REG_LIGHT_G     = 3'd4,
        REG_LIGHT_B     = 3'd5,
        REG_LIGHT_RANGE = 3'd6
    } reg_idx_t;

    // Light setup as held in the configuration registers.
    typedef struct packed {
        q16_t [2:0]  pos;
        q16_t [2:0]  col;
        logic [30:0] range;
    } light_t;

    // One classified vertex as it travels from the front end to the back end.
    typedef struct packed {
        q16_t [2:0] lv;
        q16_t [2:0] nrm;
        q16_t [2:0] col;
        logic       bypass;
    } fe_t;

    function automatic logic signed [34:0] sx35(input logic [31:0] a);
        return {{3{a[31]}}, a};
    endfunction

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -35'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

endpackage

// ===== rtl/plv_front.sv =====
// Front end: accepts vertices, forms the saturated light vector and handles
// the zero range case. Depends on plv_pkg.
module plv_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [287:0]     in_data,
    input  plv_pkg::light_t  light,
    output logic             out_valid,
    input  logic             out_ready,
    output plv_pkg::fe_t     out_item
);

    logic         valid_reg;
    plv_pkg::fe_t item_reg;
    plv_pkg::fe_t item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        item_next = '0;
        for (int c = 0; c < 3; c++) begin
            item_next.lv[c]  = plv_pkg::sat32(plv_pkg::sx35(light.pos[c])
                                              - plv_pkg::sx35(in_data[32*c +: 32]));
            item_next.nrm[c] = in_data[96 + 32*c +: 32];
            item_next.col[c] = in_data[192 + 32*c +: 32];
            // With no range the light color is a plain add and the back end
            // only has to forward the color.
            if (light.range == 31'd0) begin
                item_next.col[c] = plv_pkg::sat32(plv_pkg::sx35(in_data[192 + 32*c +: 32])
                                                  + plv_pkg::sx35(light.col[c]));
            end
        end
        item_next.bypass = (light.range == 31'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/plv_queue.sv =====
// Short register queue between the front end and the back end.
// Depends on plv_pkg. DEPTH must be at least 2.
module plv_queue #(
    parameter int unsigned DEPTH = plv_pkg::QueueDepth
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  plv_pkg::fe_t  in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output plv_pkg::fe_t  out_item
);

    localparam int unsigned PtrW = $clog2(DEPTH);
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    plv_pkg::fe_t    mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] cnt_reg;
    logic            push, pop;

    assign in_ready  = (cnt_reg != CntW'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
        return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/plv_back.sv =====
// Back end: fully pipelined shading datapath (squares, square root, normal
// division, dot product, attenuation division, color scaling, saturation).
// Depends on plv_pkg.
module plv_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  plv_pkg::fe_t     in_item,
    input  plv_pkg::light_t  light,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [95:0]      out_data
);

    localparam int unsigned SqrtSteps = 32;
    localparam int unsigned HDivSteps = 31;
    localparam int unsigned QDivSteps = 49;
    localparam int unsigned NumStages = 2 + SqrtSteps + 1 + HDivSteps + 4 + 1 + QDivSteps + 3;
    localparam logic [48:0] IClamp    = 49'h1_0000_0000_0000;
    localparam logic [64:0] TermClamp = 65'h2_0000_0000;

    typedef struct packed {
        logic [2:0][31:0] col;
        logic             bypass;
    } side_t;

    typedef struct packed {
        side_t            sd;
        logic [2:0][63:0] nsq;
        logic [2:0][63:0] lsq;
        logic [2:0][31:0] nmag;
        logic [2:0]       nneg;
        logic [2:0][31:0] lv;
    } sqr_t;

    typedef struct packed {
        side_t            sd;
        logic [63:0]      x;
        logic [63:0]      res;
        logic [63:0]      s;
        logic [2:0][31:0] nmag;
        logic [2:0]       nneg;
        logic [2:0][31:0] lv;
    } sq_t;

    typedef struct packed {
        side_t            sd;
        logic [2:0][31:0] rem;
        logic [2:0][30:0] low;
        logic [2:0][30:0] q;
        logic [31:0]      len;
        logic [63:0]      s;
        logic [2:0]       nneg;
        logic [2:0][31:0] lv;
    } dv_t;

    typedef struct packed {
        side_t            sd;
        logic [2:0][63:0] prod;
        logic [63:0]      s;
    } pp_t;

    typedef struct packed {
        side_t       sd;
        logic [63:0] dp;
        logic [63:0] s;
    } dd_t;

    typedef struct packed {
        side_t       sd;
        logic [62:0] p0;
        logic [61:0] p1;
        logic [63:0] s;
    } rr_t;

    typedef struct packed {
        side_t       sd;
        logic [79:0] x;
        logic [63:0] s;
    } xx_t;

    typedef struct packed {
        side_t       sd;
        logic        ovf;
        logic [63:0] s;
        logic [63:0] rem;
        logic [48:0] low;
        logic [48:0] q;
    } qd_t;

    typedef struct packed {
        side_t       sd;
        logic [48:0] i;
    } ii_t;

    typedef struct packed {
        side_t            sd;
        logic [2:0][63:0] pa;
        logic [2:0][48:0] pb;
    } tt_t;

    typedef struct packed {
        side_t            sd;
        logic [2:0][34:0] term;
    } mm_t;

    logic                 adv;
    logic [NumStages-1:0] vld_reg;
    logic                 out_valid_reg;
    logic [95:0]          out_data_reg, out_data_next;

    sqr_t sqr_reg, sqr_next;
    sq_t  sq_reg [0:SqrtSteps];
    sq_t  sq0_next;
    dv_t  dv_reg [0:HDivSteps];
    dv_t  dv0_next;
    pp_t  pp_reg, pp_next;
    dd_t  dd_reg, dd_next;
    rr_t  rr_reg, rr_next;
    xx_t  xx_reg, xx_next;
    qd_t  qd_reg [0:QDivSteps];
    qd_t  qd0_next;
    ii_t  ii_reg, ii_next;
    tt_t  tt_reg, tt_next;
    mm_t  mm_reg, mm_next;

    logic [93:0] rsum;

    // The whole back end moves in lockstep whenever the output register frees up.
    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg       <= {vld_reg[NumStages-2:0], in_valid};
            out_valid_reg <= vld_reg[NumStages-1];
        end
    end

    // Squares of normal and light vector components.
    always_comb begin
        sqr_next.sd.col    = in_item.col;
        sqr_next.sd.bypass = in_item.bypass;
        for (int c = 0; c < 3; c++) begin
            sqr_next.nmag[c] = plv_pkg::mag32(in_item.nrm[c]);
            sqr_next.nneg[c] = in_item.nrm[c][31];
            sqr_next.lv[c]   = in_item.lv[c];
            sqr_next.nsq[c]  = 64'(sqr_next.nmag[c]) * 64'(sqr_next.nmag[c]);
            sqr_next.lsq[c]  = 64'(plv_pkg::mag32(in_item.lv[c]))
                               * 64'(plv_pkg::mag32(in_item.lv[c]));
        end
    end

    // Sums; a zero normal leaves the color alone.
    always_comb begin
        sq0_next.x         = sqr_reg.nsq[0] + sqr_reg.nsq[1] + sqr_reg.nsq[2];
        sq0_next.s         = sqr_reg.lsq[0] + sqr_reg.lsq[1] + sqr_reg.lsq[2];
        sq0_next.res       = '0;
        sq0_next.nmag      = sqr_reg.nmag;
        sq0_next.nneg      = sqr_reg.nneg;
        sq0_next.lv        = sqr_reg.lv;
        sq0_next.sd.col    = sqr_reg.sd.col;
        sq0_next.sd.bypass = sqr_reg.sd.bypass || (sq0_next.x == 64'd0);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqr_reg   <= sqr_next;
            sq_reg[0] <= sq0_next;
        end
    end

    // Bit-by-bit integer square root, one result bit per stage.
    for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
        localparam logic [63:0] One = 64'd1 << (62 - 2*k);
        sq_t         step_next;
        logic [63:0] trial;

        always_comb begin
            step_next = sq_reg[k];
            trial     = sq_reg[k].res + One;
            if (sq_reg[k].x >= trial) begin
                step_next.x   = sq_reg[k].x - trial;
                step_next.res = (sq_reg[k].res >> 1) + One;
            end else begin
                step_next.res = sq_reg[k].res >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_reg[k+1] <= step_next;
            end
        end
    end

    // Normalization: |n| * 2^30 / len as restoring division, three lanes.
    always_comb begin
        dv0_next.sd   = sq_reg[SqrtSteps].sd;
        dv0_next.len  = sq_reg[SqrtSteps].res[31:0];
        dv0_next.s    = sq_reg[SqrtSteps].s;
        dv0_next.nneg = sq_reg[SqrtSteps].nneg;
        dv0_next.lv   = sq_reg[SqrtSteps].lv;
        for (int c = 0; c < 3; c++) begin
            dv0_next.rem[c] = sq_reg[SqrtSteps].nmag[c] >> 1;
            dv0_next.low[c] = {sq_reg[SqrtSteps].nmag[c][0], 30'd0};
            dv0_next.q[c]   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_reg[0] <= dv0_next;
        end
    end

    for (genvar k = 0; k < HDivSteps; k++) begin : g_hdiv
        dv_t              step_next;
        logic [2:0][32:0] t;

        always_comb begin
            step_next = dv_reg[k];
            for (int c = 0; c < 3; c++) begin
                t[c]                = {dv_reg[k].rem[c], dv_reg[k].low[c][30]};
                step_next.low[c]    = {dv_reg[k].low[c][29:0], 1'b0};
                if (t[c] >= {1'b0, dv_reg[k].len}) begin
                    step_next.rem[c] = 32'(t[c] - {1'b0, dv_reg[k].len});
                    step_next.q[c]   = {dv_reg[k].q[c][29:0], 1'b1};
                end else begin
                    step_next.rem[c] = t[c][31:0];
                    step_next.q[c]   = {dv_reg[k].q[c][29:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_reg[k+1] <= step_next;
            end
        end
    end

    // Dot product terms of the unit normal with the light vector.
    always_comb begin
        logic signed [31:0] nh;
        pp_next.sd = dv_reg[HDivSteps].sd;
        pp_next.s  = dv_reg[HDivSteps].s;
        for (int c = 0; c < 3; c++) begin
            nh = dv_reg[HDivSteps].nneg[c] ? -$signed({1'b0, dv_reg[HDivSteps].q[c]})
                                           : $signed({1'b0, dv_reg[HDivSteps].q[c]});
            pp_next.prod[c] = nh * $signed(dv_reg[HDivSteps].lv[c]);
        end
    end

    // A surface facing away from or edge-on to the light, or a zero light vector, keeps its color.
    always_comb begin
        dd_next.dp        = pp_reg.prod[0] + pp_reg.prod[1] + pp_reg.prod[2];
        dd_next.s         = pp_reg.s;
        dd_next.sd.col    = pp_reg.sd.col;
        dd_next.sd.bypass = pp_reg.sd.bypass || !($signed(dd_next.dp) > 64'sd0)
                            || (pp_reg.s == 64'd0);
    end

    // range * dp as two partial products.
    always_comb begin
        rr_next.sd = dd_reg.sd;
        rr_next.s  = dd_reg.s;
        rr_next.p0 = 63'(light.range) * 63'(dd_reg.dp[31:0]);
        rr_next.p1 = 62'(light.range) * 62'(dd_reg.dp[62:32]);
    end

    always_comb begin
        rsum       = {rr_reg.p1, 32'd0} + 94'(rr_reg.p0);
        xx_next.sd = rr_reg.sd;
        xx_next.s  = rr_reg.s;
        xx_next.x  = rsum[93:14];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pp_reg <= pp_next;
            dd_reg <= dd_next;
            rr_reg <= rr_next;
            xx_reg <= xx_next;
        end
    end

    // Attenuation quotient: overflow check, then 49 quotient bits.
    always_comb begin
        qd0_next.sd  = xx_reg.sd;
        qd0_next.s   = xx_reg.s;
        qd0_next.ovf = {33'd0, xx_reg.x} >= {xx_reg.s, 49'd0};
        qd0_next.rem = 64'(xx_reg.x[79:49]);
        qd0_next.low = xx_reg.x[48:0];
        qd0_next.q   = '0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            qd_reg[0] <= qd0_next;
        end
    end

    for (genvar k = 0; k < QDivSteps; k++) begin : g_qdiv
        qd_t         step_next;
        logic [64:0] t;

        always_comb begin
            step_next     = qd_reg[k];
            t             = {qd_reg[k].rem, qd_reg[k].low[48]};
            step_next.low = {qd_reg[k].low[47:0], 1'b0};
            if (t >= {1'b0, qd_reg[k].s}) begin
                step_next.rem = 64'(t - {1'b0, qd_reg[k].s});
                step_next.q   = {qd_reg[k].q[47:0], 1'b1};
            end else begin
                step_next.rem = t[63:0];
                step_next.q   = {qd_reg[k].q[47:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                qd_reg[k+1] <= step_next;
            end
        end
    end

    always_comb begin
        ii_next.sd = qd_reg[QDivSteps].sd;
        ii_next.i  = (qd_reg[QDivSteps].ovf || (qd_reg[QDivSteps].q > IClamp))
                     ? IClamp : qd_reg[QDivSteps].q;
    end

    // |light color| * i, split on the 32-bit boundary of i.
    always_comb begin
        logic [31:0] lmag;
        tt_next.sd = ii_reg.sd;
        for (int c = 0; c < 3; c++) begin
            lmag          = plv_pkg::mag32(light.col[c]);
            tt_next.pa[c] = 64'(lmag) * 64'(ii_reg.i[31:0]);
            tt_next.pb[c] = 49'(lmag) * 49'(ii_reg.i[48:32]);
        end
    end

    always_comb begin
        logic [80:0] p;
        logic [64:0] sh;
        logic [34:0] m;
        mm_next.sd = tt_reg.sd;
        for (int c = 0; c < 3; c++) begin
            p  = {tt_reg.pb[c], 32'd0} + 81'(tt_reg.pa[c]);
            sh = p[80:16];
            m  = (sh > TermClamp) ? {1'b0, TermClamp[33:0]} : {1'b0, sh[33:0]};
            mm_next.term[c] = light.col[c][31] ? (35'd0 - m) : m;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (mm_reg.sd.bypass) begin
                out_data_next[32*c +: 32] = mm_reg.sd.col[c];
            end else begin
                out_data_next[32*c +: 32] = plv_pkg::sat32(plv_pkg::sx35(mm_reg.sd.col[c])
                                                           + $signed(mm_reg.term[c]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ii_reg       <= ii_next;
            tt_reg       <= tt_next;
            mm_reg       <= mm_next;
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== rtl/point_light_vertex_shading_top.sv =====
// Top level of the point light vertex shading block: configuration
// registers, front end, queue and back end. Depends on plv_pkg and submodules.
//
//   Channel  Direction  Handshake                Payload
//   s_       in         s_tvalid / s_tready      vertex, normal, color (288 bits)
//   m_       out        m_tvalid / m_tready      lit color (96 bits)
//   APB      in         psel / penable / pready  light setup, 7 registers
//
// One vertex is accepted per clock while the queue is not full. Each vertex
// passes the front register, the queue and the back end pipeline with its
// output register; most back end stages belong to the pipelined square root,
// normal divider and attenuation divider. A stalled output
// freezes the back end; the front register and the queue of QUEUE_DEPTH
// entries keep taking vertices until full. aresetn is synchronous and clears
// all control state and the light registers.
module point_light_vertex_shading_top #(
    parameter int unsigned QUEUE_DEPTH = plv_pkg::QueueDepth
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z,
    // color_in_r, color_in_g, color_in_b (32 bits each, lowest first)
    input  logic [287:0]                    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // color_out_r, color_out_g, color_out_b (32 bits each, lowest first)
    output logic [95:0]                     m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [plv_pkg::AddrWidth-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    plv_pkg::light_t light_reg;
    plv_pkg::fe_t    fe_item, q_item;
    logic            fe_valid, fe_ready, q_valid, q_ready;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            light_reg <= '0;
        end else if (psel && penable && pwrite) begin
            case (plv_pkg::reg_idx_t'(paddr[4:2]))
                plv_pkg::REG_LIGHT_X:     light_reg.pos[0] <= pwdata;
                plv_pkg::REG_LIGHT_Y:     light_reg.pos[1] <= pwdata;
                plv_pkg::REG_LIGHT_Z:     light_reg.pos[2] <= pwdata;
                plv_pkg::REG_LIGHT_R:     light_reg.col[0] <= pwdata;
                plv_pkg::REG_LIGHT_G:     light_reg.col[1] <= pwdata;
                plv_pkg::REG_LIGHT_B:     light_reg.col[2] <= pwdata;
                plv_pkg::REG_LIGHT_RANGE: light_reg.range  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (plv_pkg::reg_idx_t'(paddr[4:2]))
            plv_pkg::REG_LIGHT_X:     prdata = light_reg.pos[0];
            plv_pkg::REG_LIGHT_Y:     prdata = light_reg.pos[1];
            plv_pkg::REG_LIGHT_Z:     prdata = light_reg.pos[2];
            plv_pkg::REG_LIGHT_R:     prdata = light_reg.col[0];
            plv_pkg::REG_LIGHT_G:     prdata = light_reg.col[1];
            plv_pkg::REG_LIGHT_B:     prdata = light_reg.col[2];
            plv_pkg::REG_LIGHT_RANGE: prdata = {1'b0, light_reg.range};
            default:                  prdata = 32'd0;
        endcase
    end

    plv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .light     (light_reg),
        .out_valid (fe_valid),
        .out_ready (fe_ready),
        .out_item  (fe_item)
    );

    plv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_item   (fe_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    plv_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .light     (light_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ===== rtl/plv_checker.sv =====
// Port-level checks for the point light vertex shading block, bound to the
// top level. Depends on plv_pkg.
module plv_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [287:0]                  s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [95:0]                   m_tdata,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [plv_pkg::AddrWidth-1:0] paddr,
    input logic [31:0]                   pwdata,
    input logic [31:0]                   prdata,
    input logic                          pready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("block not empty and ready after reset");

    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready && paddr[1:0] == 2'b00
         && paddr[4:2] == plv_pkg::REG_LIGHT_X)
        ##1 (psel && !pwrite && paddr[1:0] == 2'b00 && paddr[4:2] == plv_pkg::REG_LIGHT_X)
        |-> prdata == $past(pwdata))
        else $error("light position readback does not match the write");

endmodule

bind point_light_vertex_shading_top plv_checker u_plv_checker (.*);
